// ===== design/bxavg_pkg.sv =====
// ----------------------------------------------------------------------------
// bxavg_pkg
// Shared types and constants of the interleaved 1-D box average block.
// ----------------------------------------------------------------------------
package bxavg_pkg;

  localparam int SAMPLE_W   = 8;
  localparam int RADIUS_W   = 4;
  localparam int CHCNT_W    = 3;
  localparam int FILL_W     = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 2'd1;

  localparam logic [RADIUS_W-1:0] RADIUS_RST = 4'd1;
  localparam logic [CHCNT_W-1:0]  CHCNT_RST  = 3'd3;
  localparam logic [FILL_W-1:0]   FILL_MAX   = 7'd127;

  // control shared by every cell of the delay chain
  typedef struct packed {
    logic shift;  // an item is accepted, chain moves one step
    logic flush;  // line start: everything behind the load point reads zero
    logic clear;  // register write: wipe the whole chain
  } cell_ctrl_t;

endpackage

// ===== design/bxavg_cell.sv =====
// ----------------------------------------------------------------------------
// bxavg_cell
// One sample cell of the delay chain: loads the new item, takes its upper
// neighbor's sample, or reads zero on a clear or a flush; else it holds.
// ----------------------------------------------------------------------------
module bxavg_cell (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bxavg_pkg::cell_ctrl_t             ctrl,
  input  logic                              load,
  input  logic [bxavg_pkg::SAMPLE_W-1:0]    din,
  input  logic [bxavg_pkg::SAMPLE_W-1:0]    up,
  output logic [bxavg_pkg::SAMPLE_W-1:0]    q
);

  logic [bxavg_pkg::SAMPLE_W-1:0] q_r;
  logic [bxavg_pkg::SAMPLE_W-1:0] q_nxt;

  always_comb begin
    q_nxt = q_r;
    if (ctrl.clear) begin
      q_nxt = '0;
    end else if (ctrl.shift) begin
      if (load) begin
        q_nxt = din;
      end else if (ctrl.flush) begin
        q_nxt = '0;
      end else begin
        q_nxt = up;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

// ===== design/box_average_1d_interleaved_core.sv =====
// ----------------------------------------------------------------------------
// box_average_1d_interleaved_core
// Running box average over interleaved channel samples, one delay chain
// shared by all channels, running sum per channel, reciprocal multiply.
// ----------------------------------------------------------------------------
// pipeline: an accepted item passes the sum stage register, then the multiply stage result register, to out_tvalid
// throughput: 1 item per cycle while out_tready allows; the chain shifts and one channel sum updates
//   on every accepted item, so back-to-back items of the same channel are fine
// reset: synchronous, clears chain, sums, fill count, channel index and
//   pipeline; radius=1, channel_count=3. no clearing pass is needed
module box_average_1d_interleaved_core #(
  parameter int MAX_RADIUS   = 15,
  parameter int MAX_CHANNELS = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input items
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,  // [7:0] sample
  input  logic [0:0]                          in_tuser,  // [0] line_start
  // result items
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [7:0]                          out_tdata, // [7:0] average
  output logic [0:0]                          out_tuser, // [0] window_full
  // register writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bxavg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bxavg_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int SW       = bxavg_pkg::SAMPLE_W;
  localparam int RAD_CAP  = (MAX_RADIUS > 15) ? 15 : MAX_RADIUS;
  localparam int CH_CAP   = (MAX_CHANNELS > 7) ? 7 : MAX_CHANNELS;
  localparam int TAPS_CAP = 2 * RAD_CAP + 1;
  localparam int TAPS_W   = $clog2(TAPS_CAP + 1);
  localparam int SUM_W    = SW + TAPS_W;
  localparam int K        = SUM_W + TAPS_W;
  localparam int RCP_W    = K + 1;
  localparam int PROD_W   = SUM_W + RCP_W;
  localparam int NCELL    = TAPS_CAP * CH_CAP;
  localparam int LEN_W    = $clog2(NCELL + 1);
  localparam int RI_W     = $clog2(RAD_CAP + 1);
  localparam int CH_W     = (CH_CAP > 1) ? $clog2(CH_CAP) : 1;
  localparam int CC_W     = bxavg_pkg::CHCNT_W + 1;

  // configuration
  logic [bxavg_pkg::RADIUS_W-1:0] radius_r;
  logic [bxavg_pkg::CHCNT_W-1:0]  chcnt_r;
  logic                           cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we = cfg_valid && (cfg_index == bxavg_pkg::REG_RADIUS ||
                                cfg_index == bxavg_pkg::REG_CHANNELS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= bxavg_pkg::RADIUS_RST;
      chcnt_r  <= bxavg_pkg::CHCNT_RST;
    end else if (cfg_valid) begin
      if (cfg_index == bxavg_pkg::REG_RADIUS) begin
        radius_r <= cfg_data[bxavg_pkg::RADIUS_W-1:0];
      end
      if (cfg_index == bxavg_pkg::REG_CHANNELS) begin
        chcnt_r <= cfg_data[bxavg_pkg::CHCNT_W-1:0];
      end
    end
  end

  logic [bxavg_pkg::RADIUS_W-1:0] eff_rad;
  logic [TAPS_W-1:0]              taps;
  logic [bxavg_pkg::CHCNT_W-1:0]  chans;
  logic [LEN_W-1:0]               len;
  logic [LEN_W-1:0]               len_m1;

  always_comb begin
    eff_rad = (radius_r > bxavg_pkg::RADIUS_W'(RAD_CAP)) ?
              bxavg_pkg::RADIUS_W'(RAD_CAP) : radius_r;
    taps    = TAPS_W'({eff_rad, 1'b1});
    if (chcnt_r == '0) begin
      chans = bxavg_pkg::CHCNT_W'(1);
    end else if (chcnt_r > bxavg_pkg::CHCNT_W'(CH_CAP)) begin
      chans = bxavg_pkg::CHCNT_W'(CH_CAP);
    end else begin
      chans = chcnt_r;
    end
    // the chain is as long as one window of every channel
    len    = LEN_W'(int'(taps) * int'(chans));
    len_m1 = len - LEN_W'(1);
  end

  // exact floor division by the odd tap count: ceil(2^K / taps)
  logic [RCP_W-1:0] recip_tab [RAD_CAP+1];
  for (genvar r = 0; r <= RAD_CAP; r++) begin : g_rcp
    localparam longint RV = ((64'd1 << K) + 2 * r) / (2 * r + 1);
    assign recip_tab[r] = RCP_W'(RV);
  end

  logic [RCP_W-1:0] recip;
  assign recip = recip_tab[eff_rad[RI_W-1:0]];

  // handshake
  logic s1_valid_r;
  logic out_valid_r;
  logic out_space;
  logic acc;

  assign out_space = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || out_space;
  assign acc       = in_tvalid && in_tready;

  // delay chain
  logic                   ls;
  bxavg_pkg::cell_ctrl_t  ctrl;
  logic [SW-1:0]          cell_q [NCELL];

  assign ls         = in_tuser[0];
  assign ctrl.shift = acc;
  assign ctrl.flush = ls;
  assign ctrl.clear = cfg_we;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    logic [SW-1:0] up;
    logic          load;
    if (i == NCELL - 1) begin : g_top
      assign up = '0;
    end else begin : g_mid
      assign up = cell_q[i+1];
    end
    // new item enters at the far end of the active chain
    assign load = (int'(len_m1) == i);
    bxavg_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctrl  (ctrl),
      .load  (load),
      .din   (in_tdata),
      .up    (up),
      .q     (cell_q[i])
    );
  end

  // channel sums and line state
  logic [SUM_W-1:0]              sum_r [CH_CAP];
  logic [CH_W-1:0]               idx_r;
  logic [bxavg_pkg::FILL_W-1:0]  fill_r;

  logic [CH_W-1:0]               idx_base;
  logic [bxavg_pkg::FILL_W-1:0]  fill_base;
  logic [SUM_W-1:0]              sum_base;
  logic [SW-1:0]                 old;
  logic [SUM_W-1:0]              cur_sum;
  logic                          full;
  logic                          wrap;
  logic [CH_W-1:0]               idx_nxt;
  logic [bxavg_pkg::FILL_W-1:0]  fill_nxt;

  always_comb begin
    idx_base  = ls ? '0 : idx_r;
    fill_base = ls ? '0 : fill_r;
    sum_base  = ls ? '0 : sum_r[idx_base];
    old       = ls ? '0 : cell_q[0];
    cur_sum   = SUM_W'({1'b0, sum_base} + (SUM_W+1)'(in_tdata) - (SUM_W+1)'(old));
    full      = ((SW)'(fill_base) + SW'(1)) >= SW'(taps);
    wrap      = (CC_W'(idx_base) + CC_W'(1)) == CC_W'(chans);
    idx_nxt   = wrap ? '0 : idx_base + CH_W'(1);
    fill_nxt  = fill_base;
    if (wrap && fill_base != bxavg_pkg::FILL_MAX) begin
      fill_nxt = fill_base + bxavg_pkg::FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      idx_r  <= '0;
      fill_r <= '0;
      for (int c = 0; c < CH_CAP; c++) begin
        sum_r[c] <= '0;
      end
    end else if (acc) begin
      idx_r  <= idx_nxt;
      fill_r <= fill_nxt;
      for (int c = 0; c < CH_CAP; c++) begin
        if (CH_W'(c) == idx_base) begin
          sum_r[c] <= cur_sum;
        end else if (ls) begin
          sum_r[c] <= '0;
        end
      end
    end
  end

  // sum stage
  logic [SUM_W-1:0] s1_sum_r;
  logic             s1_full_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_sum_r  <= cur_sum;
      s1_full_r <= full;
    end
  end

  // multiply stage, result register
  logic [PROD_W-1:0] prod;
  logic [SW-1:0]     out_avg_r;
  logic              out_full_r;

  assign prod = PROD_W'(s1_sum_r) * PROD_W'(recip);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_space) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_space && s1_valid_r) begin
      out_avg_r  <= prod[K +: SW];
      out_full_r <= s1_full_r;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_avg_r;
  assign out_tuser[0] = out_full_r;

  // checks
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    CC_W'(idx_r) < CC_W'(chans))
    else $error("channel index beyond channel count");

  a_line_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && ls && !cfg_we) |=> (fill_r <= bxavg_pkg::FILL_W'(1)))
    else $error("fill count not restarted at line start");

  a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> (32'(s1_sum_r) <= 32'(taps) * 32'd255))
    else $error("window sum exceeds taps times full scale");

endmodule

// ===== verif/box_average_1d_interleaved_core_tb.sv =====
// ----------------------------------------------------------------------------
// box_average_1d_interleaved_core_tb
// Self-checking bench for the interleaved 1-D box average core. A cycle-free
// predictor keeps its own per-channel sample history and window sums and
// queues the expected average and window_full flag for every accepted item.
// Directed items hit the reset defaults, the register extremes and a long line,
// then random lines run under four idle/stall patterns with fresh register settings between segments.
// ----------------------------------------------------------------------------
module box_average_1d_interleaved_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_RAD      = 15;
  localparam int MAX_CH       = 4;
  localparam int TAPS_MAX     = 2 * MAX_RAD + 1;
  localparam int SUM_W        = 13;
  localparam int PIPE_LATENCY = 2;
  localparam int STALL_LIMIT  = 2000;

  // indexes past the register list, writes there are dropped
  localparam logic [bxavg_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [bxavg_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [bxavg_pkg::SAMPLE_W-1:0] average;
    logic                           window_full;
  } box_result_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [7:0]                       in_tdata = '0;   // [7:0] sample
  logic [0:0]                       in_tuser = '0;   // [0] line_start
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [7:0]                       out_tdata;       // [7:0] average
  logic [0:0]                       out_tuser;       // [0] window_full
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [bxavg_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [bxavg_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  box_average_1d_interleaved_core #(
    .MAX_RADIUS  (MAX_RAD),
    .MAX_CHANNELS(MAX_CH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---- predictor state ----
  logic [bxavg_pkg::SAMPLE_W-1:0] sample_hist [MAX_CH][TAPS_MAX];
  logic [SUM_W-1:0]               chan_sum [MAX_CH];
  logic [bxavg_pkg::FILL_W-1:0]   pixels_in_line;
  int unsigned                    next_chan;
  logic [bxavg_pkg::RADIUS_W-1:0] radius_set;
  logic [bxavg_pkg::CHCNT_W-1:0]  chan_set;

  box_result_t expected_avgs [$];
  int          fail_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          items_sent = 0;

  function automatic void clear_line_state();
    for (int c = 0; c < MAX_CH; c++) begin
      chan_sum[c] = '0;
      for (int k = 0; k < TAPS_MAX; k++) sample_hist[c][k] = '0;
    end
    pixels_in_line = '0;
    next_chan = 0;
  endfunction

  function automatic int unsigned active_chans();
    if (chan_set == 0) return 1;
    return (chan_set > MAX_CH) ? MAX_CH : chan_set;
  endfunction

  function automatic int unsigned active_taps();
    return 2 * int'(radius_set) + 1;
  endfunction

  function automatic void apply_reg(input logic [bxavg_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [bxavg_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      bxavg_pkg::REG_RADIUS: begin
        radius_set = data[bxavg_pkg::RADIUS_W-1:0];
        clear_line_state();
      end
      bxavg_pkg::REG_CHANNELS: begin
        chan_set = data[bxavg_pkg::CHCNT_W-1:0];
        clear_line_state();
      end
      default: ;
    endcase
  endfunction

  function automatic box_result_t window_average(
    input logic [bxavg_pkg::SAMPLE_W-1:0] sample,
    input logic line_start);
    int unsigned taps;
    int unsigned c;
    box_result_t r;
    taps = active_taps();
    if (line_start) clear_line_state();
    if (next_chan >= active_chans()) next_chan = 0;
    c = next_chan;
    chan_sum[c] = chan_sum[c] + sample - sample_hist[c][taps-1];
    for (int k = taps - 1; k > 0; k--) sample_hist[c][k] = sample_hist[c][k-1];
    sample_hist[c][0] = sample;
    r.window_full = (int'(pixels_in_line) + 1 >= int'(taps));
    r.average = bxavg_pkg::SAMPLE_W'(int'(chan_sum[c]) / int'(taps));
    next_chan = c + 1;
    if (next_chan >= active_chans()) begin
      next_chan = 0;
      if (pixels_in_line != bxavg_pkg::FILL_MAX) pixels_in_line = pixels_in_line + 1'b1;
    end
    return r;
  endfunction

  // ---- drivers ----
  task automatic send_item(input logic [7:0] sample, input logic line_start);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    expected_avgs.push_back(window_average(sample, line_start));
    in_tvalid <= 1'b1;
    in_tdata  <= sample;
    in_tuser  <= line_start;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // block must be idle: stop input and let every result drain first
  task automatic write_reg(input logic [bxavg_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bxavg_pkg::CFG_DATA_W-1:0] data);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_avgs.size() != 0);
    apply_reg(idx, data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // ---- result checker ----
  always @(posedge clk) begin
    box_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_avgs.size() == 0) begin
        $error("result item with nothing expected: average %0d window_full %0d",
               out_tdata, out_tuser[0]);
        fail_count++;
      end else begin
        want = expected_avgs.pop_front();
        if (out_tdata !== want.average) begin
          $error("average mismatch: expected %0d, actual %0d", want.average, out_tdata);
          fail_count++;
        end
        if (out_tuser[0] !== want.window_full) begin
          $error("window_full mismatch: expected %0d, actual %0d",
                 want.window_full, out_tuser[0]);
          fail_count++;
        end
      end
    end
  end

  // ---- watchdog: cycles with no handshake on any channel ----
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("box_average_1d_interleaved_core_tb failed");
      $finish;
    end
  end

  function automatic logic [7:0] pick_sample();
    case ($urandom_range(7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // ---- tests ----
  task automatic test_reset_defaults();
    // radius 1, three channels out of reset; third pixel fills the window
    send_item(8'd0, 1'b0);
    send_item(8'd255, 1'b0);
    send_item(8'd255, 1'b0);
    send_item(8'd255, 1'b0);
    send_item(8'd1, 1'b0);
    send_item(8'd254, 1'b0);
    send_item(8'd128, 1'b0);
    send_item(8'd255, 1'b0);
    send_item(8'd0, 1'b0);
  endtask

  task automatic test_register_extremes();
    // single tap, zero channel count acts as one
    write_reg(bxavg_pkg::REG_RADIUS, 4'd0);
    write_reg(bxavg_pkg::REG_CHANNELS, 4'd0);
    send_item(8'd200, 1'b1);
    send_item(8'd7, 1'b0);
    // top data bit is outside the channel field
    write_reg(bxavg_pkg::REG_RADIUS, 4'd15);
    write_reg(bxavg_pkg::REG_CHANNELS, 4'd9);
    send_item(8'd255, 1'b0);
    send_item(8'd255, 1'b0);
    send_item(8'd255, 1'b0);
    // spare indexes leave the line untouched
    write_reg(REG_SPARE_A, 4'd15);
    write_reg(REG_SPARE_B, 4'd0);
    send_item(8'd255, 1'b0);
    send_item(8'd128, 1'b0);
    // channel count above the maximum saturates
    write_reg(bxavg_pkg::REG_CHANNELS, 4'd7);
    send_item(8'd255, 1'b0);
    send_item(8'd255, 1'b0);
    send_item(8'd255, 1'b0);
    send_item(8'd255, 1'b0);
    // line start in the middle of a pixel
    write_reg(bxavg_pkg::REG_RADIUS, 4'd1);
    write_reg(bxavg_pkg::REG_CHANNELS, 4'd3);
    send_item(8'd20, 1'b0);
    send_item(8'd30, 1'b0);
    send_item(8'd10, 1'b1);
    send_item(8'd40, 1'b0);
  endtask

  task automatic test_long_line();
    // pixel count runs past its saturation point
    write_reg(bxavg_pkg::REG_RADIUS, 4'd15);
    write_reg(bxavg_pkg::REG_CHANNELS, 4'd1);
    send_item(pick_sample(), 1'b1);
    for (int i = 0; i < 139; i++) send_item(pick_sample(), 1'b0);
  endtask

  task automatic send_lines(input int budget);
    int start_count;
    int pixels;
    int len;
    int kind;
    start_count = items_sent;
    while (items_sent - start_count < budget) begin
      kind = $urandom_range(9);
      pixels = $urandom_range(1, active_taps() + 6);
      if (kind < 8) begin
        // well-formed line with random content
        len = pixels * active_chans();
        for (int i = 0; i < len; i++) send_item(pick_sample(), i == 0);
      end else if (kind == 8) begin
        // broken line: random length, may end part way through a pixel
        len = $urandom_range(1, pixels * active_chans());
        for (int i = 0; i < len; i++) send_item(pick_sample(), i == 0);
      end else begin
        for (int i = 0; i < 8; i++) send_item(pick_sample(), $urandom_range(1) == 1);
      end
    end
  endtask

  task automatic test_random_lines(input int idle_pct, input int stall_pct, input int budget);
    int start_count;
    logic [bxavg_pkg::CFG_DATA_W-1:0] rad;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start_count = items_sent;
    while (items_sent - start_count < budget) begin
      case ($urandom_range(3))
        0:       rad = 4'd0;
        1:       rad = 4'd15;
        default: rad = 4'($urandom_range(15));
      endcase
      write_reg(bxavg_pkg::REG_RADIUS, rad);
      write_reg(bxavg_pkg::REG_CHANNELS, 4'($urandom_range(15)));
      if ($urandom_range(3) == 0)
        write_reg(($urandom_range(1) == 1) ? REG_SPARE_A : REG_SPARE_B,
                  4'($urandom_range(15)));
      send_lines(60);
    end
  endtask

  initial begin
    radius_set = bxavg_pkg::RADIUS_RST;
    chan_set   = bxavg_pkg::CHCNT_RST;
    clear_line_state();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    recv_stall_pct = 0;
    send_idle_pct  = 0;
    test_reset_defaults();
    test_register_extremes();
    test_long_line();
    test_random_lines(0, 0, 150);
    test_random_lines(81, 0, 150);
    test_random_lines(0, 81, 150);
    test_random_lines(38, 38, 150);
    in_tvalid <= 1'b0;
    while (expected_avgs.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 4) @(posedge clk);
    if (fail_count == 0)
      $display("box_average_1d_interleaved_core_tb passed");
    else
      $display("box_average_1d_interleaved_core_tb failed");
    $finish;
  end

endmodule

// ===== sim.f =====
design/bxavg_pkg.sv
design/bxavg_cell.sv
design/box_average_1d_interleaved_core.sv
verif/box_average_1d_interleaved_core_tb.sv
